[sv/ray_box_slab_intersect_core_assert.svh]
// Assertion macros shared by the ray/box intersection core.
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define RBSI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbsi assertion failed");

// Clocked check that also holds during reset
`define RBSI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rbsi assertion failed");

`endif

[sv/rbsi_pkg.sv]
// Types, constants and arithmetic helpers for the ray/box slab intersection core.
package rbsi_pkg;

    localparam int CW     = 32;              // coordinate width
    localparam int FB     = 16;              // fraction bits
    localparam int NAXIS  = 3;
    localparam int QW     = 2 * FB + 1;      // quotient width of 2^(2*FB) / m
    localparam int DSTEP  = 3;               // quotient bits per divider stage
    localparam int NDIV   = (QW + DSTEP - 1) / DSTEP;
    localparam int DW     = NDIV * DSTEP;
    localparam int PW     = 2 * CW + 1;      // product width
    localparam int SHW    = PW - FB;         // product width after scaling
    localparam int MAGW   = (DW > SHW) ? DW : SHW;

    // pipeline stage numbers
    localparam int ST_IN  = 0;
    localparam int ST_RCP = NDIV + 1;
    localparam int ST_MUL = NDIV + 2;
    localparam int ST_SAT = NDIV + 3;
    localparam int ST_ORD = NDIV + 4;
    localparam int ST_MRG = NDIV + 5;
    localparam int NST    = NDIV + 6;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
    localparam logic [MAGW-1:0] LIM_NEG = MAGW'(1) << (CW - 1);
    localparam logic [MAGW-1:0] LIM_POS = LIM_NEG - MAGW'(1);

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] t_near;
        logic signed [CW-1:0] t_far;
    } t_ray_out;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic [NST-1:0] en;
    } t_pipe_ctl;

    // divider stage contents, with the slab distances riding along
    typedef struct packed {
        logic [CW-1:0]      rem;
        logic [DW-1:0]      q;
        logic [CW-1:0]      m;
        logic               neg;
        logic               zero;
        logic signed [CW:0] dlo;
        logic signed [CW:0] dhi;
    } t_div;

    // DSTEP restoring steps of 2^(2*FB) / m
    function automatic t_div div_stage(t_div s, int unsigned stg);
        t_div        o;
        logic [CW:0] sh;
        int unsigned bi;
        o = s;
        for (int unsigned j = 0; j < DSTEP; j++) begin
            bi = DW - 1 - (stg * DSTEP + j);
            sh = {o.rem, (bi == 2 * FB)};
            if (sh >= {1'b0, o.m}) begin
                sh = sh - {1'b0, o.m};
                o.q[bi] = 1'b1;
            end
            o.rem = sh[CW-1:0];
        end
        return o;
    endfunction

    // signed saturation of a magnitude and sign
    function automatic logic signed [CW-1:0] sat_mag(logic [MAGW-1:0] mag, logic neg);
        logic signed [CW-1:0] res;
        if (neg) begin
            res = (mag > LIM_NEG) ? MINV : -$signed(mag[CW-1:0]);
        end else begin
            res = (mag > LIM_POS) ? MAXV : $signed(mag[CW-1:0]);
        end
        return res;
    endfunction

endpackage

[sv/rbsi_lane.sv]
// One axis slab: pipelined reciprocal, scaling multiplies and per-axis ordering.
module rbsi_lane (
    input  logic                          i_clk,
    input  rbsi_pkg::t_pipe_ctl           i_ctl,
    input  logic signed [rbsi_pkg::CW-1:0] i_bmin,
    input  logic signed [rbsi_pkg::CW-1:0] i_bmax,
    input  logic signed [rbsi_pkg::CW-1:0] i_origin,
    input  logic signed [rbsi_pkg::CW-1:0] i_dir,
    output logic signed [rbsi_pkg::CW-1:0] o_lo,
    output logic signed [rbsi_pkg::CW-1:0] o_hi
);

    rbsi_pkg::t_div r_s [0:rbsi_pkg::NDIV];

    logic signed [rbsi_pkg::CW-1:0] r_rcp;
    logic signed [rbsi_pkg::CW:0]   r_dlo, r_dhi;
    logic [rbsi_pkg::PW-1:0]        r_p0, r_p1;
    logic                           r_n0, r_n1;
    logic signed [rbsi_pkg::CW-1:0] r_t0, r_t1;

    logic [rbsi_pkg::CW-1:0] mag_r;
    logic [rbsi_pkg::CW:0]   mag_lo, mag_hi;

    // input capture: direction magnitude and slab distances
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_IN]) begin
            r_s[0].rem  <= '0;
            r_s[0].q    <= '0;
            r_s[0].m    <= i_dir[rbsi_pkg::CW-1] ? (~i_dir + 1'b1) : i_dir;
            r_s[0].neg  <= i_dir[rbsi_pkg::CW-1];
            r_s[0].zero <= (i_dir == '0);
            r_s[0].dlo  <= {i_bmin[rbsi_pkg::CW-1], i_bmin}
                         - {i_origin[rbsi_pkg::CW-1], i_origin};
            r_s[0].dhi  <= {i_bmax[rbsi_pkg::CW-1], i_bmax}
                         - {i_origin[rbsi_pkg::CW-1], i_origin};
        end
    end

    // divider stages
    for (genvar k = 1; k <= rbsi_pkg::NDIV; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[k]) begin
                r_s[k] <= rbsi_pkg::div_stage(r_s[k-1], k - 1);
            end
        end
    end

    // reciprocal saturation; zero direction gives the largest value
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_RCP]) begin
            r_rcp <= r_s[rbsi_pkg::NDIV].zero ? rbsi_pkg::MAXV :
                     rbsi_pkg::sat_mag(rbsi_pkg::MAGW'(r_s[rbsi_pkg::NDIV].q),
                                       r_s[rbsi_pkg::NDIV].neg);
            r_dlo <= r_s[rbsi_pkg::NDIV].dlo;
            r_dhi <= r_s[rbsi_pkg::NDIV].dhi;
        end
    end

    // magnitude multiplies
    assign mag_r  = r_rcp[rbsi_pkg::CW-1] ? (~r_rcp + 1'b1) : r_rcp;
    assign mag_lo = r_dlo[rbsi_pkg::CW] ? (~r_dlo + 1'b1) : r_dlo;
    assign mag_hi = r_dhi[rbsi_pkg::CW] ? (~r_dhi + 1'b1) : r_dhi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_MUL]) begin
            r_p0 <= rbsi_pkg::PW'(mag_r) * rbsi_pkg::PW'(mag_lo);
            r_p1 <= rbsi_pkg::PW'(mag_r) * rbsi_pkg::PW'(mag_hi);
            r_n0 <= r_rcp[rbsi_pkg::CW-1] ^ r_dlo[rbsi_pkg::CW];
            r_n1 <= r_rcp[rbsi_pkg::CW-1] ^ r_dhi[rbsi_pkg::CW];
        end
    end

    // drop fraction bits and saturate
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_SAT]) begin
            r_t0 <= rbsi_pkg::sat_mag(
                rbsi_pkg::MAGW'(r_p0[rbsi_pkg::PW-1:rbsi_pkg::FB]), r_n0);
            r_t1 <= rbsi_pkg::sat_mag(
                rbsi_pkg::MAGW'(r_p1[rbsi_pkg::PW-1:rbsi_pkg::FB]), r_n1);
        end
    end

    // order the two plane distances
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_ORD]) begin
            o_lo <= (r_t0 < r_t1) ? r_t0 : r_t1;
            o_hi <= (r_t0 > r_t1) ? r_t0 : r_t1;
        end
    end

endmodule

[sv/rbsi_merge.sv]
// Merge of the three axis intervals into entry, exit and hit.
module rbsi_merge (
    input  logic                           i_clk,
    input  rbsi_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [rbsi_pkg::CW-1:0] i_lo [rbsi_pkg::NAXIS],
    input  logic signed [rbsi_pkg::CW-1:0] i_hi [rbsi_pkg::NAXIS],
    output rbsi_pkg::t_ray_out             o_res
);

    logic signed [rbsi_pkg::CW-1:0] tn, tf;

    // largest entry, smallest exit
    always_comb begin
        tn = i_lo[0];
        tf = i_hi[0];
        for (int a = 1; a < rbsi_pkg::NAXIS; a++) begin
            if (i_lo[a] > tn) tn = i_lo[a];
            if (i_hi[a] < tf) tf = i_hi[a];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[rbsi_pkg::ST_MRG]) begin
            o_res.hit    <= (tf > tn);
            o_res.t_near <= tn;
            o_res.t_far  <= tf;
        end
    end

endmodule

[sv/ray_box_slab_intersect_core.sv]
// Ray versus axis-aligned box test, one lane per axis and a merge stage.
// Stages: input capture, 11 divider stages, reciprocal, multiply, saturate, order
// and merge; the result is valid when the merge stage holds a ray.
// Throughput: one ray per cycle while the output is ready; a full stage holds while
// the one after it cannot move, so gaps close up under output stalls.
// Reset clears all stage valid flags and the six box registers to zero.
`include "ray_box_slab_intersect_core_assert.svh"

module ray_box_slab_intersect_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rbsi_pkg::t_ray_in                 i_ray,
    output logic                              o_valid,
    input  logic                              i_ready,
    output rbsi_pkg::t_ray_out                o_res,
    input  logic                              i_cfg_wen,
    input  logic [rbsi_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  logic [rbsi_pkg::CW-1:0]           i_cfg_wdata
);

    logic signed [rbsi_pkg::CW-1:0] r_box_min [rbsi_pkg::NAXIS];
    logic signed [rbsi_pkg::CW-1:0] r_box_max [rbsi_pkg::NAXIS];
    logic [rbsi_pkg::NST-1:0]       r_v;
    rbsi_pkg::t_pipe_ctl            ctl;

    logic signed [rbsi_pkg::CW-1:0] origin [rbsi_pkg::NAXIS];
    logic signed [rbsi_pkg::CW-1:0] dir    [rbsi_pkg::NAXIS];
    logic signed [rbsi_pkg::CW-1:0] lo     [rbsi_pkg::NAXIS];
    logic signed [rbsi_pkg::CW-1:0] hi     [rbsi_pkg::NAXIS];

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < rbsi_pkg::NAXIS; a++) begin
                r_box_min[a] <= '0;
                r_box_max[a] <= '0;
            end
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                rbsi_pkg::REG_BOX_MIN_X: r_box_min[0] <= i_cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Y: r_box_min[1] <= i_cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Z: r_box_min[2] <= i_cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_X: r_box_max[0] <= i_cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Y: r_box_max[1] <= i_cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Z: r_box_max[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        ctl.en[rbsi_pkg::NST-1] = !r_v[rbsi_pkg::NST-1] | i_ready;
        for (int s = rbsi_pkg::NST - 2; s >= 0; s--) begin
            ctl.en[s] = !r_v[s] | ctl.en[s+1];
        end
    end

    assign o_ready = ctl.en[rbsi_pkg::ST_IN];
    assign o_valid = r_v[rbsi_pkg::NST-1];

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ctl.en[0]) r_v[0] <= i_valid;
            for (int s = 1; s < rbsi_pkg::NST; s++) begin
                if (ctl.en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    assign origin[0] = i_ray.origin_x;
    assign origin[1] = i_ray.origin_y;
    assign origin[2] = i_ray.origin_z;
    assign dir[0]    = i_ray.dir_x;
    assign dir[1]    = i_ray.dir_y;
    assign dir[2]    = i_ray.dir_z;

    // one lane per axis
    for (genvar a = 0; a < rbsi_pkg::NAXIS; a++) begin : g_lane
        rbsi_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_bmin   (r_box_min[a]),
            .i_bmax   (r_box_max[a]),
            .i_origin (origin[a]),
            .i_dir    (dir[a]),
            .o_lo     (lo[a]),
            .o_hi     (hi[a])
        );
    end

    rbsi_merge u_merge (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_lo  (lo),
        .i_hi  (hi),
        .o_res (o_res)
    );

    // checks
    `RBSI_ASSERT(a_hit_cmp, i_clk, i_rst_n,
        o_valid |-> (o_res.hit == (o_res.t_far > o_res.t_near)))
    `RBSI_ASSERT(a_full_stall, i_clk, i_rst_n, ((&r_v) && !i_ready) |-> !o_ready)
    `RBSI_ASSERT_ALWAYS(a_ready_room, i_clk, !o_ready |-> r_v[0])

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ray versus box slab intersection core.
`timescale 1ns / 100ps

module tb_top;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    rbsi_pkg::t_ray_in i_ray;
    logic o_valid;
    logic i_ready;
    rbsi_pkg::t_ray_out o_res;
    logic i_cfg_wen;
    logic [rbsi_pkg::CFG_IW-1:0] i_cfg_idx;
    logic [rbsi_pkg::CW-1:0] i_cfg_wdata;

    ray_box_slab_intersect_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_ray(i_ray),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // Box corners as the predictor sees them
    logic signed [rbsi_pkg::CW-1:0] box_lo [rbsi_pkg::NAXIS];
    logic signed [rbsi_pkg::CW-1:0] box_hi [rbsi_pkg::NAXIS];

    rbsi_pkg::t_ray_in  ray_queue [$];
    rbsi_pkg::t_ray_out hit_queue [$];
    int mismatches = 0;
    bit calm = 0;         // no random idling while set
    bit drain_hold = 0;   // receiver holds off while set
    bit sender_pause = 0;
    bit in_fire = 0;      // input transfer at the last rising edge

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    // Saturate a signed 66-bit value to the coordinate range
    function automatic logic signed [rbsi_pkg::CW-1:0] clamp_coord(logic signed [65:0] v);
        if (v > 66'sd2147483647) return rbsi_pkg::MAXV;
        if (v < -66'sd2147483648) return rbsi_pkg::MINV;
        return v[rbsi_pkg::CW-1:0];
    endfunction

    // 2^32 / dir, truncated toward zero; zero direction gives the top value
    function automatic logic signed [rbsi_pkg::CW-1:0] inv_dir(
            logic signed [rbsi_pkg::CW-1:0] d);
        logic [63:0] mag;
        logic [63:0] q;
        if (d == 0) return rbsi_pkg::MAXV;
        mag = d < 0 ? 64'(-64'(d)) : 64'(d);
        q = (64'd1 << (2 * rbsi_pkg::FB)) / mag;
        return clamp_coord(d < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q}));
    endfunction

    // (r * diff) >> FB toward zero, saturated
    function automatic logic signed [rbsi_pkg::CW-1:0] scale_dist(
            logic signed [rbsi_pkg::CW-1:0] r, logic signed [rbsi_pkg::CW:0] diff);
        logic signed [65:0] p;
        logic [65:0] mag;
        p = 66'(r) * 66'(diff);
        mag = p < 0 ? 66'(-p) : 66'(p);
        mag = mag >> rbsi_pkg::FB;
        return clamp_coord(p < 0 ? -$signed(mag) : $signed(mag));
    endfunction

    function automatic rbsi_pkg::t_ray_out predict_hit(rbsi_pkg::t_ray_in ray);
        logic signed [rbsi_pkg::CW-1:0] org [rbsi_pkg::NAXIS];
        logic signed [rbsi_pkg::CW-1:0] dir [rbsi_pkg::NAXIS];
        logic signed [rbsi_pkg::CW-1:0] r, t0, t1, tn, tf, lo, hi;
        rbsi_pkg::t_ray_out res;
        org = '{ray.origin_x, ray.origin_y, ray.origin_z};
        dir = '{ray.dir_x, ray.dir_y, ray.dir_z};
        for (int a = 0; a < rbsi_pkg::NAXIS; a++) begin
            r = inv_dir(dir[a]);
            t0 = scale_dist(r, 33'(box_lo[a]) - 33'(org[a]));
            t1 = scale_dist(r, 33'(box_hi[a]) - 33'(org[a]));
            lo = t0 < t1 ? t0 : t1;
            hi = t0 > t1 ? t0 : t1;
            if (a == 0 || lo > tn) tn = lo;
            if (a == 0 || hi < tf) tf = hi;
        end
        res.hit = tf > tn;
        res.t_near = tn;
        res.t_far = tf;
        return res;
    endfunction

    // Driver: offers rays from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (i_valid && !in_fire) begin
            // hold the offered ray
        end else if (ray_queue.size() > 0 && !sender_pause &&
                     (calm || $urandom_range(99) >= 29)) begin
            i_valid <= 1;
            i_ray <= ray_queue.pop_front();
        end else begin
            i_valid <= 0;
        end
        i_ready <= !drain_hold && (calm || $urandom_range(99) >= 29);
    end

    // Monitor: predicts on input transfer, checks on output transfer
    always @(posedge i_clk) begin
        rbsi_pkg::t_ray_out want;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) hit_queue.push_back(predict_hit(i_ray));
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_res);
            end else begin
                want = hit_queue.pop_front();
                if (want.hit !== o_res.hit || want.t_near !== o_res.t_near ||
                    want.t_far !== o_res.t_far) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, o_res);
                end
            end
        end
    end

    task automatic write_box(logic [rbsi_pkg::CFG_IW-1:0] idx,
                             logic signed [rbsi_pkg::CW-1:0] v);
        @(negedge i_clk);
        i_cfg_wen <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_wen <= 0;
        if (idx == rbsi_pkg::REG_BOX_MIN_X) box_lo[0] = v;
        if (idx == rbsi_pkg::REG_BOX_MIN_Y) box_lo[1] = v;
        if (idx == rbsi_pkg::REG_BOX_MIN_Z) box_lo[2] = v;
        if (idx == rbsi_pkg::REG_BOX_MAX_X) box_hi[0] = v;
        if (idx == rbsi_pkg::REG_BOX_MAX_Y) box_hi[1] = v;
        if (idx == rbsi_pkg::REG_BOX_MAX_Z) box_hi[2] = v;
    endtask

    task automatic set_box(logic signed [rbsi_pkg::CW-1:0] x0, y0, z0, x1, y1, z1);
        write_box(rbsi_pkg::REG_BOX_MIN_X, x0);
        write_box(rbsi_pkg::REG_BOX_MIN_Y, y0);
        write_box(rbsi_pkg::REG_BOX_MIN_Z, z0);
        write_box(rbsi_pkg::REG_BOX_MAX_X, x1);
        write_box(rbsi_pkg::REG_BOX_MAX_Y, y1);
        write_box(rbsi_pkg::REG_BOX_MAX_Z, z1);
    endtask

    // Wait for every pending ray to be sent and answered
    task automatic drain();
        while (ray_queue.size() > 0 || i_valid || hit_queue.size() > 0)
            @(posedge i_clk);
        repeat (rbsi_pkg::NST + 4) @(posedge i_clk);
    endtask

    // Random coordinate: mostly small values, some full range and extremes
    function automatic logic signed [rbsi_pkg::CW-1:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? rbsi_pkg::MAXV : rbsi_pkg::MINV;
            2: return $signed(32'($urandom_range(255))) - 128;
            3: return 0;
            default: return $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
        endcase
    endfunction

    task automatic queue_random(int n);
        rbsi_pkg::t_ray_in ray;
        for (int i = 0; i < n; i++) begin
            ray.origin_x = rand_coord();
            ray.origin_y = rand_coord();
            ray.origin_z = rand_coord();
            ray.dir_x = rand_coord();
            ray.dir_y = rand_coord();
            ray.dir_z = rand_coord();
            ray_queue.push_back(ray);
        end
    endtask

    function automatic rbsi_pkg::t_ray_in mk_ray(
            logic signed [rbsi_pkg::CW-1:0] ox, oy, oz, dx, dy, dz);
        rbsi_pkg::t_ray_in r;
        r = '{ox, oy, oz, dx, dy, dz};
        return r;
    endfunction

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_ray = '0;
        i_cfg_wen = 0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        for (int a = 0; a < rbsi_pkg::NAXIS; a++) begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: unit box, axis rays, zero and tiny directions, extremes
        set_box(-32'sh10000, -32'sh10000, -32'sh10000,
                32'sh10000, 32'sh10000, 32'sh10000);
        ray_queue.push_back(mk_ray(-32'sh50000, 0, 0, 32'sh10000, 0, 0));
        ray_queue.push_back(mk_ray(0, -32'sh50000, 0, 0, 32'sh10000, 0));
        ray_queue.push_back(mk_ray(0, 0, 32'sh50000, 0, 0, -32'sh10000));
        ray_queue.push_back(mk_ray(32'sh10000, 0, 0, 0, 32'sh10000, 0));
        ray_queue.push_back(mk_ray(32'sh50000, 32'sh50000, 0, 32'sh10000, 0, 0));
        ray_queue.push_back(mk_ray(0, 0, 0, 1, -1, 1));
        ray_queue.push_back(mk_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(mk_ray(rbsi_pkg::MAXV, rbsi_pkg::MINV, rbsi_pkg::MAXV,
                                   rbsi_pkg::MINV, rbsi_pkg::MAXV, rbsi_pkg::MINV));
        ray_queue.push_back(mk_ray(rbsi_pkg::MINV, rbsi_pkg::MAXV, rbsi_pkg::MINV,
                                   rbsi_pkg::MAXV, rbsi_pkg::MINV, rbsi_pkg::MAXV));
        ray_queue.push_back(mk_ray(0, 0, 0, -1, 2, -2));
        ray_queue.push_back(mk_ray(-1, -1, -1, 32'sh8000, -32'sh8000, 32'sh7fff));
        ray_queue.push_back(mk_ray(32'sh123456, -32'sh654321, 7, 3, -5, 32'sh10000));
        drain();

        // Inverted box at the extremes, then random rays
        set_box(rbsi_pkg::MAXV, rbsi_pkg::MAXV, rbsi_pkg::MAXV,
                rbsi_pkg::MINV, rbsi_pkg::MINV, rbsi_pkg::MINV);
        ray_queue.push_back(mk_ray(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000));
        ray_queue.push_back(mk_ray(rbsi_pkg::MAXV, rbsi_pkg::MINV, 0, 0, 0, -1));
        ray_queue.push_back(mk_ray(rbsi_pkg::MINV, rbsi_pkg::MINV, rbsi_pkg::MINV,
                                   1, 1, 1));
        queue_random(150);
        drain();

        // Receiver holds off long while the sender keeps offering rays
        set_box(-32'sh30000, -32'sh20000, -32'sh40000,
                32'sh30000, 32'sh50000, 32'sh10000);
        calm = 1;
        drain_hold = 1;
        queue_random(100);
        repeat (200) @(posedge i_clk);
        drain_hold = 0;
        drain();
        calm = 0;

        // Random box settings, with a stretch of no idling and a sender pause
        for (int phase = 0; phase < 5; phase++) begin
            set_box(rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
            calm = (phase == 2);
            queue_random(120);
            if (phase == 3) begin
                // sender pauses until every result is in, then resumes
                while (ray_queue.size() > 60) @(posedge i_clk);
                sender_pause = 1;
                while (i_valid || hit_queue.size() > 0) @(posedge i_clk);
                sender_pause = 0;
            end
            drain();
        end
        calm = 0;

        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
